FILE: rtl/core/wbt_pkg.sv
// ============================================================================
// wbt_pkg
// Shared types, codes and constants of the work / break timer.
// ============================================================================
package wbt_pkg;

    // Defaults of the top-level parameters
    localparam int HOUR_BITS_DEF         = 8;
    localparam int MAX_BREAK_MINUTES_DEF = 29;

    // Fixed field widths
    localparam int SEC_W      = 6;
    localparam int TENTH_W    = 4;
    localparam int WMIN_W     = 6;
    localparam int SHOWN_HR_W = 8;
    localparam int BMIN_OUT_W = 5;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    localparam logic [SEC_W-1:0]   SEC_MAX         = 6'd59;
    localparam logic [WMIN_W-1:0]  MIN_MAX         = 6'd59;
    localparam logic [TENTH_W-1:0] TENTH_MAX       = 4'd9;
    localparam logic [SEC_W-1:0]   BRK_SECS_RESET  = 6'd15;

    // Operating mode, one-hot
    typedef enum logic [3:0] {
        MODE_WORK  = 4'b0001,
        MODE_BREAK = 4'b0010,
        MODE_READY = 4'b0100,
        MODE_SET   = 4'b1000
    } mode_t;

    // Mode codes as shown on the result item
    localparam logic [1:0] CODE_WORK  = 2'd0;
    localparam logic [1:0] CODE_BREAK = 2'd1;
    localparam logic [1:0] CODE_READY = 2'd2;
    localparam logic [1:0] CODE_SET   = 2'd3;

    // Report codes
    localparam logic [1:0] REP_NONE      = 2'd0;
    localparam logic [1:0] REP_LINK_FAIL = 2'd1;
    localparam logic [1:0] REP_SEND_WORK = 2'd2;
    localparam logic [1:0] REP_SEND_BRK  = 2'd3;

    // One input item
    typedef struct packed {
        logic link_up;
        logic tick;
        logic step_up;
        logic go_setting;
        logic go_break;
        logic go_work;
    } item_t;

    // One result item
    typedef struct packed {
        logic [1:0]            report;
        logic                  alarm_drive;
        logic [SEC_W-1:0]      break_left_seconds;
        logic [BMIN_OUT_W-1:0] break_left_minutes;
        logic [SEC_W-1:0]      shown_seconds;
        logic [WMIN_W-1:0]     shown_minutes;
        logic [SHOWN_HR_W-1:0] shown_hours;
        logic [1:0]            cur_mode;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            MODE_WORK:  c = CODE_WORK;
            MODE_BREAK: c = CODE_BREAK;
            MODE_READY: c = CODE_READY;
            MODE_SET:   c = CODE_SET;
            default:    c = CODE_READY;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/wbt_core.sv
// ============================================================================
// wbt_core
// Timer state and its single-pass update for one item.
// ============================================================================
module wbt_core #(
    parameter int HOUR_BITS         = wbt_pkg::HOUR_BITS_DEF,
    parameter int MAX_BREAK_MINUTES = wbt_pkg::MAX_BREAK_MINUTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  wbt_pkg::item_t              item,
    input  logic [wbt_pkg::SEC_W-1:0]   ready_secs,
    output wbt_pkg::result_t            result
);
    import wbt_pkg::*;

    localparam int BMIN_W = $clog2(MAX_BREAK_MINUTES + 1);
    localparam int BMIN_X = (BMIN_W > BMIN_OUT_W) ? BMIN_W : BMIN_OUT_W;
    localparam int HR_X   = (HOUR_BITS > SHOWN_HR_W) ? HOUR_BITS : SHOWN_HR_W;
    localparam logic [BMIN_W-1:0] BMIN_MAX = BMIN_W'(MAX_BREAK_MINUTES);

    mode_t                mode_reg, mode_next;
    logic [TENTH_W-1:0]   wt_reg, wt_next, st_reg, st_next, bt_reg, bt_next;
    logic [SEC_W-1:0]     ws_reg, ws_next, ss_reg, ss_next;
    logic [SEC_W-1:0]     bs_reg, bs_next, ks_reg, ks_next;
    logic [WMIN_W-1:0]    wm_reg, wm_next, sm_reg, sm_next;
    logic [HOUR_BITS-1:0] wh_reg, wh_next, sh_reg, sh_next;
    logic [BMIN_W-1:0]    bm_reg, bm_next, km_reg, km_next;
    logic                 alarm_reg, alarm_next, drive_reg, drive_next;
    logic [1:0]           report;
    logic [HR_X-1:0]      hrs_ext;
    logic [BMIN_X-1:0]    bmin_ext;

    always_comb begin
        mode_next  = mode_reg;
        wt_next = wt_reg; ws_next = ws_reg; wm_next = wm_reg; wh_next = wh_reg;
        st_next = st_reg; ss_next = ss_reg; sm_next = sm_reg; sh_next = sh_reg;
        bt_next = bt_reg; bs_next = bs_reg; bm_next = bm_reg;
        ks_next = ks_reg; km_next = km_reg;
        alarm_next = alarm_reg;
        drive_next = drive_reg;
        report     = REP_NONE;

        // Button presses: green, then red, then blue
        if (item.go_work) begin
            if (mode_next != MODE_WORK) begin
                if (!item.link_up) begin
                    report = REP_LINK_FAIL;
                end else begin
                    alarm_next = 1'b0;
                    drive_next = 1'b0;
                    report     = REP_SEND_WORK;
                end
            end
            mode_next = MODE_WORK;
        end
        if (item.go_break) begin
            if (mode_next != MODE_BREAK) begin
                report = item.link_up ? REP_SEND_BRK : REP_LINK_FAIL;
            end
            mode_next = MODE_BREAK;
        end
        if (item.go_setting) begin
            mode_next = MODE_SET;
        end

        if (item.tick) begin
            // work stopwatch
            if (wt_next == TENTH_MAX) begin
                wt_next = '0;
                if (ws_next == SEC_MAX) begin
                    ws_next = '0;
                    if (wm_next == MIN_MAX) begin
                        wm_next = '0;
                        wh_next = wh_next + 1'b1;
                    end else begin
                        wm_next = wm_next + 1'b1;
                    end
                end else begin
                    ws_next = ws_next + 1'b1;
                end
            end else begin
                wt_next = wt_next + 1'b1;
            end

            // break countdown, clamps at zero
            if (mode_next == MODE_BREAK) begin
                if (bt_next == '0) begin
                    bt_next = TENTH_MAX;
                    if (bs_next == '0) begin
                        if (bm_next == '0) begin
                            bs_next    = '0;
                            alarm_next = 1'b1;
                        end else begin
                            bs_next = SEC_MAX;
                            bm_next = bm_next - 1'b1;
                        end
                    end else begin
                        bs_next = bs_next - 1'b1;
                    end
                end else begin
                    bt_next = bt_next - 1'b1;
                end
            end

            case (mode_next)
                MODE_WORK: begin
                    st_next = wt_next; ss_next = ws_next;
                    sm_next = wm_next; sh_next = wh_next;
                    bs_next = ks_next; bm_next = km_next;
                    alarm_next = 1'b0;
                end
                MODE_BREAK: begin
                    wt_next = st_next; ws_next = ss_next;
                    wm_next = sm_next; wh_next = sh_next;
                    if (alarm_next) begin
                        drive_next = 1'b1;
                    end
                end
                MODE_READY: begin
                    wt_next = '0; ws_next = '0; wm_next = '0; wh_next = '0;
                    bm_next = '0;
                    bs_next = ready_secs;
                end
                MODE_SET: begin
                    if (!alarm_next) begin
                        wt_next = st_next; ws_next = ss_next;
                        wm_next = sm_next; wh_next = sh_next;
                        if (item.step_up) begin
                            if (bs_next >= SEC_MAX) begin
                                if (bm_next >= BMIN_MAX) begin
                                    bm_next = '0;
                                end else begin
                                    bm_next = bm_next + 1'b1;
                                end
                                bs_next = '0;
                            end else begin
                                bs_next = bs_next + 1'b1;
                            end
                        end
                        if (item.go_setting) begin
                            if (bs_next == '0) begin
                                if (bm_next == '0) begin
                                    bs_next = '0;
                                end else begin
                                    bm_next = bm_next - 1'b1;
                                    bs_next = SEC_MAX;
                                end
                            end else begin
                                bs_next = bs_next - 1'b1;
                            end
                        end
                        km_next = bm_next;
                        ks_next = bs_next;
                    end
                end
                default: begin
                    mode_next = MODE_READY;
                end
            endcase
        end

        hrs_ext  = HR_X'(sh_next);
        bmin_ext = BMIN_X'(bm_next);
        result.cur_mode           = mode_code(mode_next);
        result.shown_hours        = hrs_ext[SHOWN_HR_W-1:0];
        result.shown_minutes      = sm_next;
        result.shown_seconds      = ss_next;
        result.break_left_minutes = bmin_ext[BMIN_OUT_W-1:0];
        result.break_left_seconds = bs_next;
        result.alarm_drive        = drive_next;
        result.report             = report;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_READY;
            wt_reg <= '0; ws_reg <= '0; wm_reg <= '0; wh_reg <= '0;
            st_reg <= '0; ss_reg <= '0; sm_reg <= '0; sh_reg <= '0;
            bt_reg <= '0; bs_reg <= BRK_SECS_RESET; bm_reg <= '0;
            ks_reg <= BRK_SECS_RESET; km_reg <= '0;
            alarm_reg <= 1'b0;
            drive_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            wt_reg <= wt_next; ws_reg <= ws_next; wm_reg <= wm_next; wh_reg <= wh_next;
            st_reg <= st_next; ss_reg <= ss_next; sm_reg <= sm_next; sh_reg <= sh_next;
            bt_reg <= bt_next; bs_reg <= bs_next; bm_reg <= bm_next;
            ks_reg <= ks_next; km_reg <= km_next;
            alarm_reg <= alarm_next;
            drive_reg <= drive_next;
        end
    end

endmodule

FILE: rtl/core/wbt_cfg.sv
// ============================================================================
// wbt_cfg
// Ready-mode break seconds register, saturated to 59 on write.
// ============================================================================
module wbt_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [wbt_pkg::SEC_W-1:0] cfg_wdata,
    output logic [wbt_pkg::SEC_W-1:0] ready_secs
);
    import wbt_pkg::*;

    logic [SEC_W-1:0] ready_secs_reg, ready_secs_next;

    always_comb begin
        ready_secs_next = ready_secs_reg;
        if (cfg_we) begin
            ready_secs_next = (cfg_wdata > SEC_MAX) ? SEC_MAX : cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_secs_reg <= BRK_SECS_RESET;
        end else begin
            ready_secs_reg <= ready_secs_next;
        end
    end

    assign ready_secs = ready_secs_reg;

endmodule

FILE: rtl/core/work_break_timer.sv
// ============================================================================
// work_break_timer
// Work stopwatch, break countdown with alarm, and break length setting.
// ============================================================================
// Pipeline: an accepted item is held in the input register; its result is
//   loaded into the result register and shown on m_ once that stage can take it.
// Throughput: one item per cycle unless m_tready stalls; one update pass each.
// Reset: aresetn low at a clock edge clears both stages, puts the timer in
//   ready mode with a 0:15 break and sets the register back to 15 seconds.
module work_break_timer #(
    parameter int HOUR_BITS         = wbt_pkg::HOUR_BITS_DEF,
    parameter int MAX_BREAK_MINUTES = wbt_pkg::MAX_BREAK_MINUTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // go_work, go_break, go_setting, step_up, tick, link_up, 2 bits zero
    input  logic [wbt_pkg::IN_DATA_W-1:0]  s_tdata,
    // result item
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cur_mode[1:0], shown_hours[9:2], shown_minutes[15:10],
    // shown_seconds[21:16], break_left_minutes[26:22],
    // break_left_seconds[32:27], alarm_drive[33], report[35:34], zeros
    output logic [wbt_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration: ready_break_seconds
    input  logic                           cfg_we,
    input  logic [wbt_pkg::SEC_W-1:0]      cfg_wdata
);
    import wbt_pkg::*;

    // Input stage
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    // Result stage
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    logic             advance;
    logic             accept;
    result_t          step_res;
    logic [SEC_W-1:0] ready_secs;

    // Item in the input stage moves on when the result stage is free
    // or is being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    wbt_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .ready_secs (ready_secs)
    );

    // Timer state is committed only when the item leaves the input stage.
    wbt_core #(
        .HOUR_BITS         (HOUR_BITS),
        .MAX_BREAK_MINUTES (MAX_BREAK_MINUTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .item       (in_item_reg),
        .ready_secs (ready_secs),
        .result     (step_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_res_reg);

endmodule

FILE: rtl/core/wbt_checker.sv
// ============================================================================
// wbt_checker
// Port-level checks of the work / break timer, bound to the top level.
// ============================================================================
module wbt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wbt_pkg::OUT_DATA_W-1:0] m_tdata
);
    import wbt_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a working report clears the buzzer and leaves working or setting mode
    a_work_rep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35:34] == REP_SEND_WORK |->
            !m_tdata[33] && (m_tdata[1:0] == CODE_WORK || m_tdata[1:0] == CODE_SET))
        else $error("working report with wrong mode or buzzer");

    // a break report leaves break or setting mode
    a_brk_rep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35:34] == REP_SEND_BRK |->
            m_tdata[1:0] == CODE_BREAK || m_tdata[1:0] == CODE_SET)
        else $error("break report with wrong mode");

    // remaining break seconds stay in range
    a_brk_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[32:27] <= SEC_MAX)
        else $error("break seconds out of range");

endmodule

bind work_break_timer wbt_checker u_wbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/work_break_timer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// work_break_timer_tb
// Self-checking bench: drives loop passes into the timer, mirrors the
// stopwatch, break countdown, setting steps and alarm in a local model, and
// compares every result item field by field with random stalls on both sides.
// ============================================================================
module work_break_timer_tb;
    import wbt_pkg::*;

    localparam int TB_HOUR_BITS   = HOUR_BITS_DEF;
    localparam int HOUR_MASK      = (1 << TB_HOUR_BITS) - 1;
    localparam int RANDOM_ITEMS   = 800;
    // The limit leaves ample headroom over a full run.
    localparam int unsigned CYCLE_LIMIT = 100000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // go_work, go_break, go_setting, step_up, tick, link_up, 2 bits zero
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // cur_mode, shown_hours, shown_minutes, shown_seconds,
    // break_left_minutes, break_left_seconds, alarm_drive, report, zeros
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [SEC_W-1:0]      cfg_wdata;

    work_break_timer #(
        .HOUR_BITS         (TB_HOUR_BITS),
        .MAX_BREAK_MINUTES (MAX_BREAK_MINUTES_DEF)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Local timer model state (reset values)
    // ------------------------------------------------------------------
    logic [1:0] mode_now      = CODE_READY;
    int         work_t        = 0;
    int         work_s        = 0;
    int         work_m        = 0;
    int         work_h        = 0;
    int         snap_t        = 0;
    int         snap_s        = 0;
    int         snap_m        = 0;
    int         snap_h        = 0;
    int         brk_t         = 0;
    int         brk_s         = BRK_SECS_RESET;
    int         brk_m         = 0;
    int         kept_s        = BRK_SECS_RESET;
    int         kept_m        = 0;
    bit         alarm_on      = 1'b0;
    bit         buzzer_on     = 1'b0;
    int         ready_secs    = BRK_SECS_RESET;

    result_t     expected_readouts[$];
    int          mismatches      = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int unsigned cycle_count     = 0;
    bit          steady_run      = 1'b0;   // suppress idling on both sides

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // One loop pass of the timer: update model state, return the readout
    // ------------------------------------------------------------------
    function automatic result_t advance_timer(input item_t it);
        result_t    res;
        logic [1:0] rep;
        rep = REP_NONE;
        // green, then red, then blue; last green/red mode change sets report
        if (it.go_work) begin
            if (mode_now != CODE_WORK) begin
                if (!it.link_up) begin
                    rep = REP_LINK_FAIL;
                end else begin
                    alarm_on  = 1'b0;
                    buzzer_on = 1'b0;
                    rep       = REP_SEND_WORK;
                end
            end
            mode_now = CODE_WORK;
        end
        if (it.go_break) begin
            if (mode_now != CODE_BREAK)
                rep = it.link_up ? REP_SEND_BRK : REP_LINK_FAIL;
            mode_now = CODE_BREAK;
        end
        if (it.go_setting)
            mode_now = CODE_SET;

        if (it.tick) begin
            work_t++;
            if (work_t > TENTH_MAX) begin work_s++; work_t = 0; end
            if (work_s > SEC_MAX) begin work_m++; work_s = 0; end
            if (work_m > MIN_MAX) begin
                work_h = (work_h + 1) & HOUR_MASK;
                work_m = 0;
            end

            // break countdown clamps at 0:00 and raises the alarm
            if (mode_now == CODE_BREAK) begin
                brk_t--;
                if (brk_t < 0) begin brk_s--; brk_t = TENTH_MAX; end
                if (brk_s < 0) begin brk_s = SEC_MAX; brk_m--; end
                if (brk_m < 0) begin brk_m = 0; brk_s = 0; alarm_on = 1'b1; end
            end

            case (mode_now)
                CODE_WORK: begin
                    snap_t   = work_t;
                    snap_s   = work_s;
                    snap_m   = work_m;
                    snap_h   = work_h;
                    brk_s    = kept_s;
                    brk_m    = kept_m;
                    alarm_on = 1'b0;
                end
                CODE_BREAK: begin
                    work_t = snap_t; work_s = snap_s; work_m = snap_m; work_h = snap_h;
                    if (alarm_on)
                        buzzer_on = 1'b1;
                end
                CODE_READY: begin
                    work_t = 0; work_s = 0; work_m = 0; work_h = 0;
                    brk_m  = 0;
                    brk_s  = ready_secs;
                end
                default: begin
                    // setting mode is frozen while the alarm is set
                    if (!alarm_on) begin
                        work_t = snap_t; work_s = snap_s; work_m = snap_m; work_h = snap_h;
                        if (it.step_up) begin
                            brk_s++;
                            if (brk_s > SEC_MAX) begin brk_m++; brk_s = 0; end
                            if (brk_m > MAX_BREAK_MINUTES_DEF) begin
                                brk_m = 0;
                                brk_s = 0;
                            end
                        end
                        if (it.go_setting) begin
                            brk_s--;
                            if (brk_s < 0) begin brk_m--; brk_s = SEC_MAX; end
                            if (brk_m < 0) begin brk_m = 0; brk_s = 0; end
                        end
                        kept_m = brk_m;
                        kept_s = brk_s;
                    end
                end
            endcase
        end

        res.cur_mode           = mode_now;
        res.shown_hours        = SHOWN_HR_W'(snap_h);
        res.shown_minutes      = WMIN_W'(snap_m);
        res.shown_seconds      = SEC_W'(snap_s);
        res.break_left_minutes = BMIN_OUT_W'(brk_m);
        res.break_left_seconds = SEC_W'(brk_s);
        res.alarm_drive        = buzzer_on;
        res.report             = rep;
        return res;
    endfunction

    function automatic item_t pass_of(input bit gw, input bit gb, input bit gs,
                                      input bit up, input bit tk, input bit lk);
        item_t it;
        it.go_work    = gw;
        it.go_break   = gb;
        it.go_setting = gs;
        it.step_up    = up;
        it.tick       = tk;
        it.link_up    = lk;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------
    // tvalid stays high after an accepted item; it is lowered only by a gap
    // or by wait_all_results, so it never toggles twice in one step.
    task automatic send_item(input item_t it);
        while (!steady_run && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_readouts.push_back(advance_timer(it));
        items_sent++;
    endtask

    // Stop sending, let every outstanding result drain, then keep waiting
    // to cover the two-stage pipe.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_readouts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_break_seconds(input logic [SEC_W-1:0] v);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        ready_secs = (v > SEC_MAX) ? SEC_MAX : v;   // saturated on write
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge aclk)
        m_tready <= steady_run || ($urandom_range(99) >= 34);

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (expected_readouts.size() == 0) begin
                $error("result item with no expected result pending");
                mismatches++;
            end else begin
                want = expected_readouts.pop_front();
                results_checked++;
                compare_field("cur_mode", want.cur_mode, got.cur_mode);
                compare_field("shown_hours", want.shown_hours, got.shown_hours);
                compare_field("shown_minutes", want.shown_minutes, got.shown_minutes);
                compare_field("shown_seconds", want.shown_seconds, got.shown_seconds);
                compare_field("break_left_minutes", want.break_left_minutes,
                              got.break_left_minutes);
                compare_field("break_left_seconds", want.break_left_seconds,
                              got.break_left_seconds);
                compare_field("alarm_drive", want.alarm_drive, got.alarm_drive);
                compare_field("report", want.report, got.report);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Ready mode is only reachable right after reset, so the register is
    // exercised here before any mode press. Ends with a 0:00 break loaded.
    task automatic test_ready_loading();
        logic [SEC_W-1:0] vals[5];
        vals = '{6'd59, 6'd60, 6'd63, 6'd37, 6'd0};
        send_item(pass_of(0, 0, 0, 0, 1, 1));   // default 15 s
        send_item(pass_of(0, 0, 0, 1, 0, 0));
        foreach (vals[i]) begin
            write_break_seconds(vals[i]);
            send_item(pass_of(0, 0, 0, 0, 0, 1));
            send_item(pass_of(0, 0, 0, 1, 1, 0));
            send_item(pass_of(0, 0, 0, 0, 1, 1));
        end
    endtask

    task automatic test_directed_presses();
        send_item(pass_of(0, 0, 1, 0, 1, 1));   // step down from 0:00 clamps
        send_item(pass_of(0, 0, 0, 1, 1, 1));   // step up
        send_item(pass_of(0, 0, 1, 1, 1, 1));   // up and down together
        send_item(pass_of(0, 0, 0, 0, 1, 0));
        send_item(pass_of(1, 0, 0, 0, 0, 0));   // green, link down
        send_item(pass_of(0, 0, 0, 0, 1, 1));
        send_item(pass_of(1, 0, 0, 0, 1, 1));   // green, no mode change
        send_item(pass_of(0, 1, 0, 0, 0, 0));   // red, link down
        send_item(pass_of(0, 1, 0, 0, 1, 1));   // red, no mode change
        send_item(pass_of(1, 0, 0, 0, 0, 1));   // green, link up
        send_item(pass_of(0, 1, 0, 0, 1, 1));   // red, link up
        send_item(pass_of(1, 1, 0, 0, 1, 1));   // green and red together
        send_item(pass_of(1, 1, 0, 0, 0, 0));
        send_item(pass_of(1, 1, 1, 1, 1, 1));   // every button
        send_item(pass_of(0, 0, 0, 0, 0, 0));
        send_item(pass_of(0, 1, 1, 0, 1, 1));
        send_item(pass_of(1, 0, 1, 0, 1, 0));
        send_item(pass_of(1, 0, 0, 0, 1, 1));
    endtask

    // Short break run out to the alarm, then the alarm/buzzer interplay
    task automatic test_break_alarm();
        send_item(pass_of(1, 0, 0, 0, 1, 1));
        send_item(pass_of(0, 0, 1, 0, 1, 1));
        repeat (3) send_item(pass_of(0, 0, 0, 1, 1, 1));
        send_item(pass_of(1, 0, 0, 0, 1, 1));   // load break from kept length
        send_item(pass_of(0, 1, 0, 0, 0, 1));
        repeat (100) send_item(pass_of(0, 0, 0, 0, 1, 1));
        // setting is frozen while alarmed
        send_item(pass_of(0, 0, 1, 0, 1, 1));
        send_item(pass_of(0, 0, 0, 1, 1, 1));
        send_item(pass_of(0, 0, 1, 1, 1, 0));
        send_item(pass_of(0, 1, 0, 0, 1, 1));
        // link down keeps the buzzer; work tick clears only the flag
        send_item(pass_of(1, 0, 0, 0, 0, 0));
        repeat (3) send_item(pass_of(0, 0, 0, 0, 1, 1));
        send_item(pass_of(0, 1, 0, 0, 1, 1));
        send_item(pass_of(1, 0, 0, 0, 1, 1));   // green with link clears buzzer
        send_item(pass_of(0, 0, 0, 0, 1, 1));
    endtask

    // Step the break length up across minute boundaries, then back down
    task automatic test_setting_steps();
        write_break_seconds(6'($urandom_range(63)));
        send_item(pass_of(1, 0, 0, 0, 1, 1));
        send_item(pass_of(0, 0, 1, 0, 1, 1));
        repeat (130) send_item(pass_of(0, 0, 0, 1, 1, 1'($urandom_range(1))));
        repeat (80) send_item(pass_of(0, 0, 1, 0, 1, 1'($urandom_range(1))));
    endtask

    // Runs of passes in one mode with random content, plus some noise
    task automatic test_random_passes();
        int    count;
        int    run_len;
        int    pick;
        bit    paused;
        item_t it;
        count  = 0;
        paused = 1'b0;
        while (count < RANDOM_ITEMS) begin
            if (!paused && count >= RANDOM_ITEMS / 2) begin
                // hold the sender until the pipe is empty, then reconfigure
                write_break_seconds(6'($urandom_range(63)));
                paused = 1'b1;
            end
            steady_run = ($urandom_range(9) == 0);
            pick       = $urandom_range(9);
            run_len    = $urandom_range(1, 40);
            for (int i = 0; i < run_len; i++) begin
                it.go_work    = 1'b0;
                it.go_break   = 1'b0;
                it.go_setting = 1'b0;
                it.step_up    = ($urandom_range(99) < 30);
                it.tick       = ($urandom_range(99) < 80);
                it.link_up    = ($urandom_range(99) < 85);
                if (i == 0) begin
                    if (pick <= 2)      it.go_work    = 1'b1;
                    else if (pick <= 5) it.go_break   = 1'b1;
                    else if (pick <= 8) it.go_setting = 1'b1;
                    else begin
                        it.go_work  = 1'($urandom_range(1));
                        it.go_break = 1'($urandom_range(1));
                    end
                end else if (pick >= 6 && pick <= 8) begin
                    it.go_setting = ($urandom_range(99) < 15);   // step down
                end
                if ($urandom_range(99) < 5)
                    it = item_t'(6'($urandom_range(63)));
                send_item(it);
                count++;
            end
        end
        steady_run = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ready_loading();
        test_directed_presses();
        test_break_alarm();
        test_setting_steps();
        test_random_passes();

        wait_all_results();
        repeat (8) @(posedge aclk);
        if (expected_readouts.size() != 0) begin
            $error("%0d expected results never arrived", expected_readouts.size());
            mismatches++;
        end

        $display("Covered ready loading with saturated register values, link up/down mode");
        $display("presses, break alarm, setting steps and random passes: %0d items, %0d checked",
                 items_sent, results_checked);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/wbt_pkg.sv
rtl/core/wbt_core.sv
rtl/core/wbt_cfg.sv
rtl/core/work_break_timer.sv
rtl/core/wbt_checker.sv
sim/work_break_timer_tb.sv
